FILE: sv/histogram_kernel_density_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the histogram kernel density block
// Concurrent checks on the rising clock edge, dropped for synthesis.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_KERNEL_DENSITY_DEFINES_SVH
`define HISTOGRAM_KERNEL_DENSITY_DEFINES_SVH
`ifndef SYNTHESIS
// check outside reset
`define HKD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error("hkd check failed");
// check that also holds across reset
`define HKD_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) else $error("hkd reset check failed");
`else
`define HKD_ASSERT(lbl, prop)
`define HKD_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: sv/hkd_pkg.sv
// ----------------------------------------------------------------------------
// hkd_pkg
// Types, codes and the kernel table function of the histogram density block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package hkd_pkg;

   localparam int BINS_DEF           = 256;
   localparam int KERNEL_ENTRIES_DEF = 256;
   // widest bin index over the parameter range (4096 bins)
   localparam int MAX_BIN_W          = 12;
   localparam int QUEUE_DEPTH        = 2;
   localparam int QUEUE_PTR_W        = 1;

   localparam logic [63:0] ONE_Q32          = 64'h1_0000_0000;
   localparam logic [63:0] INV_SQRT_2PI_Q32 = 64'd1713444047;

   // input actions
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_COUNTED = 2'd0;
   localparam logic [1:0] KIND_SKIPPED = 2'd1;
   localparam logic [1:0] KIND_DENSITY = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_RANGE_MIN     = 3'd0;
   localparam logic [2:0] CSR_RANGE_MAX     = 3'd1;
   localparam logic [2:0] CSR_BIN_WIDTH     = 3'd2;
   localparam logic [2:0] CSR_INV_BIN_WIDTH = 3'd3;
   localparam logic [2:0] CSR_ZERO_BAND     = 3'd4;
   localparam logic [2:0] CSR_INV_BANDWIDTH = 3'd5;
   localparam logic [2:0] CSR_INV_NORM      = 3'd6;

   typedef struct packed {
      logic               action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  bin_index;
      logic [31:0] density;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] range_min;
      logic signed [31:0] range_max;
      logic [31:0]        bin_width;
      logic [31:0]        inv_bin_width;
      logic [15:0]        zero_band;
      logic [31:0]        inv_bandwidth;
      logic [31:0]        inv_norm;
   } cfg_type;

   // work handed from front to back
   typedef enum logic [1:0] {
      OP_COUNT,
      OP_SKIP,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [MAX_BIN_W-1:0]   bin;
      logic signed [31:0]     value;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD,
      ST_WR,
      ST_SCAN,
      ST_DRAIN,
      ST_FHI,
      ST_FLO
   } back_state_type;

   // Gaussian kernel entry idx, Q0.32; x = 2^37 / entries^2
   function automatic logic [31:0] kernel_entry(input logic [63:0] x, input int idx);
      logic [63:0] t;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] g;
      logic [63:0] r;
      logic [63:0] p;
      t = ONE_Q32;
      a = ONE_Q32;
      // exp(-x) by Taylor series to the sixth power
      for (int k = 1; k <= 6; k++) begin
         t = ((t * x) >> 32) / 64'(k);
         if (k[0]) begin
            a = a - t;
         end else begin
            a = a + t;
         end
      end
      a2 = (a * a) >> 32;
      g  = ONE_Q32;
      r  = a;
      for (int k = 0; k < idx; k++) begin
         g = (g * r) >> 32;
         r = (r * a2) >> 32;
      end
      p = (g * INV_SQRT_2PI_Q32) >> 32;
      return p[31:0];
   endfunction

endpackage
`default_nettype wire

FILE: sv/histogram_kernel_density.sv
// ----------------------------------------------------------------------------
// histogram_kernel_density
// Histogram of uniform bins with a Gaussian kernel density query.
// ----------------------------------------------------------------------------
// Items go in on req_data when start is high and busy is low; action 0 adds a
// sample, action 1 asks for the density at the given point. Every item gives
// exactly one result beat on rsp_data, marked by rsp_valid for one cycle; the
// receiver cannot hold results off.
// Registers are written on the csr_ channel (index, data); csr_ready is always
// high. Write them only while the block is idle.
// For a density query the back walks the bin memory one bin per cycle through
// the kernel pipe, then scales the sum in two steps.
// A counted sample holds the back through the bin memory read-modify-write;
// a query holds the back for its whole pass while the front and its two-entry
// queue keep taking items until full.
// After reset the bin memory is cleared one bin per cycle, with busy high;
// registers return to their reset values at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module histogram_kernel_density #(
   parameter int BINS           = hkd_pkg::BINS_DEF,
   parameter int KERNEL_ENTRIES = hkd_pkg::KERNEL_ENTRIES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire hkd_pkg::req_type req_data,
   output logic                  rsp_valid,
   output hkd_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_data
);

   hkd_pkg::cfg_type   cfg_ff;
   logic               accept;
   logic               front_stall;
   logic               clearing;
   logic               q_push, q_full, q_valid, q_pop;
   hkd_pkg::entry_type q_in, q_out;

   assign csr_ready = 1'b1;
   assign busy      = clearing | front_stall;
   assign accept    = start & ~busy;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_min     <= 32'sd0;
         cfg_ff.range_max     <= 32'sd16777216;
         cfg_ff.bin_width     <= 32'd65536;
         cfg_ff.inv_bin_width <= 32'd65536;
         cfg_ff.zero_band     <= 16'd1;
         cfg_ff.inv_bandwidth <= 32'd65536;
         cfg_ff.inv_norm      <= 32'd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hkd_pkg::CSR_RANGE_MIN:     cfg_ff.range_min     <= csr_data;
            hkd_pkg::CSR_RANGE_MAX:     cfg_ff.range_max     <= csr_data;
            hkd_pkg::CSR_BIN_WIDTH:     cfg_ff.bin_width     <= csr_data;
            hkd_pkg::CSR_INV_BIN_WIDTH: cfg_ff.inv_bin_width <= csr_data;
            hkd_pkg::CSR_ZERO_BAND:     cfg_ff.zero_band     <= csr_data[15:0];
            hkd_pkg::CSR_INV_BANDWIDTH: cfg_ff.inv_bandwidth <= csr_data;
            hkd_pkg::CSR_INV_NORM:      cfg_ff.inv_norm      <= csr_data;
            default: ;
         endcase
      end
   end

   hkd_front #(
      .BINS(BINS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in),
      .stall    (front_stall)
   );

   hkd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .pop_data  (q_out)
   );

   hkd_back #(
      .BINS           (BINS),
      .KERNEL_ENTRIES (KERNEL_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: sv/hkd_front.sv
// ----------------------------------------------------------------------------
// hkd_front
// Takes items, tests the zero band, clamps and bins samples, queues the work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hkd_front #(
   parameter int BINS = hkd_pkg::BINS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire hkd_pkg::req_type req_data,
   input  wire hkd_pkg::cfg_type cfg,
   input  wire logic             q_full,
   output logic                  q_push,
   output hkd_pkg::entry_type    q_data,
   output logic                  stall
);

   localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;

   logic               s1_v_ff, s1_v_in;
   logic               s1_act_ff;
   logic signed [31:0] s1_val_ff;
   logic               s2_v_ff, s2_v_in;
   hkd_pkg::op_type    s2_op_ff, s2_op_in;
   logic [31:0]        s2_off_ff, s2_off_in;
   logic signed [31:0] s2_val_ff;
   logic               s1_go, s2_go;

   logic signed [32:0] vext, rmin, rmaxm1, c1, c2, diff;
   logic [32:0]        mag;
   logic [63:0]        prod;
   logic [BIN_W-1:0]   idx;

   // stage handshake
   assign s2_go  = s2_v_ff & ~q_full;
   assign s1_go  = s1_v_ff & (~s2_v_ff | s2_go);
   assign stall  = s1_v_ff & ~s1_go;
   assign s1_v_in = accept | (s1_v_ff & ~s1_go);
   assign s2_v_in = s1_go | (s2_v_ff & ~s2_go);

   // zero band test and clamp into the range
   always_comb begin
      vext   = {s1_val_ff[31], s1_val_ff};
      mag    = vext[32] ? 33'(-vext) : 33'(vext);
      rmin   = {cfg.range_min[31], cfg.range_min};
      rmaxm1 = {cfg.range_max[31], cfg.range_max} - 33'sd1;
      c1     = (vext < rmin) ? rmin : vext;
      c2     = (c1 > rmaxm1) ? rmaxm1 : c1;
      diff   = c2 - rmin;
      s2_off_in = (c2 > rmin) ? diff[31:0] : 32'd0;
      if (s1_act_ff == hkd_pkg::ACT_QUERY) begin
         s2_op_in = hkd_pkg::OP_QUERY;
      end else if (mag < {17'd0, cfg.zero_band}) begin
         s2_op_in = hkd_pkg::OP_SKIP;
      end else begin
         s2_op_in = hkd_pkg::OP_COUNT;
      end
   end

   // bin index from the offset, saturated to the last bin
   always_comb begin
      prod = 64'(s2_off_ff) * 64'(cfg.inv_bin_width);
      idx  = (prod[63:32] >= 32'(BINS)) ? BIN_W'(BINS - 1) : prod[BIN_W-1+32:32];
      q_push       = s2_go;
      q_data.op    = s2_op_ff;
      q_data.bin   = (s2_op_ff == hkd_pkg::OP_COUNT) ? hkd_pkg::MAX_BIN_W'(idx) : '0;
      q_data.value = s2_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_act_ff <= req_data.action;
         s1_val_ff <= req_data.value;
      end
      if (s1_go) begin
         s2_op_ff  <= s2_op_in;
         s2_off_ff <= s2_off_in;
         s2_val_ff <= s1_val_ff;
      end
   end

endmodule
`default_nettype wire

FILE: sv/hkd_queue.sv
// ----------------------------------------------------------------------------
// hkd_queue
// Short work queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hkd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire hkd_pkg::entry_type push_data,
   input  wire logic               pop,
   output logic                    full,
   output logic                    not_empty,
   output hkd_pkg::entry_type      pop_data
);

   localparam int CNT_W = hkd_pkg::QUEUE_PTR_W + 1;

   hkd_pkg::entry_type                slot_ff [hkd_pkg::QUEUE_DEPTH];
   logic [hkd_pkg::QUEUE_PTR_W-1:0]   wp_ff, rp_ff;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(hkd_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = slot_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wp_ff <= wp_ff + hkd_pkg::QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rp_ff <= rp_ff + hkd_pkg::QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: sv/hkd_back.sv
// ----------------------------------------------------------------------------
// hkd_back
// Owns the bin memory: clears it, counts samples, runs the density pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "histogram_kernel_density_defines.svh"
module hkd_back #(
   parameter int BINS           = hkd_pkg::BINS_DEF,
   parameter int KERNEL_ENTRIES = hkd_pkg::KERNEL_ENTRIES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire hkd_pkg::cfg_type   cfg,
   input  wire logic               q_valid,
   input  wire hkd_pkg::entry_type q_data,
   output logic                    q_pop,
   output logic                    clearing,
   output logic                    rsp_valid,
   output hkd_pkg::rsp_type        rsp_data
);

   localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int KW    = $clog2(KERNEL_ENTRIES);
   localparam logic [63:0] KX =
      (64'd1 << 37) / 64'(KERNEL_ENTRIES * KERNEL_ENTRIES);

   // kernel table, built at elaboration
   logic [31:0] kt [KERNEL_ENTRIES];
   for (genvar k = 0; k < KERNEL_ENTRIES; k++) begin : g_ktab
      localparam logic [31:0] KVAL = hkd_pkg::kernel_entry(KX, k);
      assign kt[k] = KVAL;
   end

   hkd_pkg::back_state_type state_ff, state_in;
   logic [BIN_W-1:0]   cnt_ff;
   hkd_pkg::entry_type ent_ff;
   logic [31:0]        mem [BINS];
   logic [31:0]        rd_ff;
   logic               mem_we;
   logic [BIN_W-1:0]   waddr, raddr;
   logic [31:0]        wdata;
   logic               last_bin;
   logic               rsp_valid_in;
   hkd_pkg::rsp_type   rsp_in;
   logic               rsp_valid_ff;
   hkd_pkg::rsp_type   rsp_ff;

   // scan pipeline
   logic signed [49:0] centre_ff, centre0, cdelta;
   logic [49:0]        ad;
   logic [3:0]         pv_ff;
   logic [49:0]        ad1_ff;
   logic [66:0]        prod1;
   logic               ok1;
   logic               ok2_ff;
   logic [18:0]        u2_ff;
   logic [31:0]        cnt2_ff, cnt3_ff;
   logic [32:0]        ki_full;
   logic [31:0]        kv3_ff, kv_in;
   logic [63:0]        tprod;
   logic [47:0]        term4_ff;
   logic [63:0]        sum_ff;
   logic [63:0]        ph_ff;
   logic [63:0]        pl;
   logic [64:0]        dens;

   assign last_bin  = (cnt_ff == BIN_W'(BINS - 1));
   assign clearing  = (state_ff == hkd_pkg::ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      waddr        = ent_ff.bin[BIN_W-1:0];
      wdata        = (rd_ff == 32'hFFFF_FFFF) ? rd_ff : rd_ff + 32'd1;
      raddr        = (state_ff == hkd_pkg::ST_SCAN) ? cnt_ff : ent_ff.bin[BIN_W-1:0];
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      pl           = 64'(sum_ff[31:0]) * 64'(cfg.inv_norm);
      dens         = 65'(ph_ff) + 65'(pl[63:32]);
      case (state_ff)
         hkd_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            waddr  = cnt_ff;
            wdata  = '0;
            if (last_bin) begin
               state_in = hkd_pkg::ST_IDLE;
            end
         end
         hkd_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_data.op)
                  hkd_pkg::OP_SKIP: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.kind  = hkd_pkg::KIND_SKIPPED;
                  end
                  hkd_pkg::OP_COUNT: state_in = hkd_pkg::ST_RD;
                  hkd_pkg::OP_QUERY: state_in = hkd_pkg::ST_SCAN;
                  default: state_in = hkd_pkg::ST_IDLE;
               endcase
            end
         end
         hkd_pkg::ST_RD: state_in = hkd_pkg::ST_WR;
         hkd_pkg::ST_WR: begin
            mem_we           = 1'b1;
            rsp_valid_in     = 1'b1;
            rsp_in.kind      = hkd_pkg::KIND_COUNTED;
            rsp_in.bin_index = 8'(ent_ff.bin[BIN_W-1:0]);
            state_in         = hkd_pkg::ST_IDLE;
         end
         hkd_pkg::ST_SCAN: begin
            if (last_bin) begin
               state_in = hkd_pkg::ST_DRAIN;
            end
         end
         hkd_pkg::ST_DRAIN: begin
            if (pv_ff == '0) begin
               state_in = hkd_pkg::ST_FHI;
            end
         end
         hkd_pkg::ST_FHI: state_in = hkd_pkg::ST_FLO;
         hkd_pkg::ST_FLO: begin
            rsp_valid_in   = 1'b1;
            rsp_in.kind    = hkd_pkg::KIND_DENSITY;
            rsp_in.density = (dens[64:32] != '0) ? 32'hFFFF_FFFF : dens[31:0];
            state_in       = hkd_pkg::ST_IDLE;
         end
         default: state_in = hkd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hkd_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         pv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pv_ff        <= {pv_ff[2:0], (state_ff == hkd_pkg::ST_SCAN)};
         if (state_ff == hkd_pkg::ST_CLEAR || state_ff == hkd_pkg::ST_SCAN) begin
            cnt_ff <= last_bin ? '0 : cnt_ff + BIN_W'(1);
         end
      end
   end

   // bin memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   // distance to the current bin centre
   always_comb begin
      centre0 = 50'(cfg.range_min) + 50'(cfg.bin_width >> 1);
      cdelta  = 50'(ent_ff.value) - centre_ff;
      ad      = cdelta[49] ? 50'(-cdelta) : 50'(cdelta);
      prod1   = 67'(ad1_ff[34:0]) * 67'(cfg.inv_bandwidth);
      // u beyond the table span is dropped; zero scale gives u = 0
      ok1     = (cfg.inv_bandwidth == '0) ||
                ((ad1_ff[49:35] == '0) && (prod1[66:35] == '0));
      ki_full = (33'(u2_ff) * 33'(KERNEL_ENTRIES) + 33'(1 << 18)) >> 19;
      kv_in   = (ok2_ff && ki_full < 33'(KERNEL_ENTRIES)) ? kt[ki_full[KW-1:0]] : 32'd0;
      tprod   = 64'(cnt3_ff) * 64'(kv3_ff);
   end

   // scan datapath and result register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (q_pop) begin
         ent_ff    <= q_data;
         centre_ff <= centre0;
         sum_ff    <= '0;
      end else if (state_ff == hkd_pkg::ST_SCAN) begin
         centre_ff <= centre_ff + 50'(cfg.bin_width);
      end
      ad1_ff   <= ad;
      ok2_ff   <= ok1;
      u2_ff    <= prod1[34:16];
      cnt2_ff  <= rd_ff;
      kv3_ff   <= kv_in;
      cnt3_ff  <= cnt2_ff;
      term4_ff <= tprod[63:16];
      if (pv_ff[3] && !q_pop) begin
         sum_ff <= sum_ff + 64'(term4_ff);
      end
      ph_ff <= 64'(sum_ff[63:32]) * 64'(cfg.inv_norm);
   end

   `HKD_ASSERT_RST(a_reset_clears, reset |=> (state_ff == hkd_pkg::ST_CLEAR))
   `HKD_ASSERT(a_no_rsp_clearing, clearing |-> !rsp_valid_ff)
   `HKD_ASSERT(a_pop_when_idle, q_pop |-> (state_ff == hkd_pkg::ST_IDLE) && q_valid)
   `HKD_ASSERT(a_drained_before_final, (state_ff == hkd_pkg::ST_FHI) |-> (pv_ff == '0))
   `HKD_ASSERT(a_final_emits, (state_ff == hkd_pkg::ST_FLO) |=> rsp_valid_ff)

endmodule
`default_nettype wire
